>>> design/smr_pkg.sv
// Shared types, codes and helpers for the sequenced message resequencer.
package smr_pkg;

    localparam int STORE_DEPTH_DEF = 64;

    typedef enum logic [1:0] {
        OP_LIVE     = 2'd0,
        OP_BACKFILL = 2'd1,
        OP_READ     = 2'd2,
        OP_CLEAR    = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_INVALID    = 4'd0,
        ST_DUPLICATE  = 4'd1,
        ST_IN_ORDER   = 4'd2,
        ST_BUFFERED   = 4'd3,
        ST_BF_SKIPPED = 4'd4,
        ST_BF_ADDED   = 4'd5,
        ST_NOT_BUFFER = 4'd6,
        ST_OVERFLOW   = 4'd7,
        ST_CLEARED    = 4'd8,
        ST_READ       = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_EVAL  = 2'd1,
        S_APPLY = 2'd2,
        S_RESP  = 2'd3
    } state_t;

    typedef struct packed {
        logic [31:0] stream_id;
        logic [31:0] seq_number;
        logic [62:0] sent_time;
        logic [31:0] payload_tag;
    } entry_t;

    typedef struct packed {
        logic eval;
        logic insert;
    } cell_ctrl_t;

    function automatic logic key_le(input entry_t a, input entry_t b);
        logic res;
        if (a.stream_id != b.stream_id) begin
            res = $signed(a.stream_id) < $signed(b.stream_id);
        end else begin
            res = $signed(a.seq_number) <= $signed(b.seq_number);
        end
        return res;
    endfunction

endpackage

>>> design/sequenced_message_resequencer_unit.sv
// Top level of the sequenced message resequencer: control, last marker and cell chain.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | opcode, stream id, seq number, time, tag, index
//  m_      | out       | m_valid / m_ready  | status, flags, count, last marker, read entry
//
// Each item passes through four states: accept, cell compare and read select, commit, result.
// The cell chain compares every slot at once; on insert the commit cycle shifts the chain by one.
// The next item is taken in the cycle after the result is taken; m_ready low holds it.
// Reset (aresetn low, synchronous) empties the store, closes the gap and zeroes the marker.
module sequenced_message_resequencer_unit import smr_pkg::*; #(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF,
    parameter int CNT_W       = $clog2(STORE_DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_opcode,
    input  logic [31:0]      s_stream_id,
    input  logic [31:0]      s_seq_number,
    input  logic [62:0]      s_sent_time,
    input  logic [31:0]      s_payload_tag,
    input  logic [5:0]       s_read_index,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [3:0]       m_status,
    output logic             m_accepted,
    output logic             m_buffering,
    output logic [CNT_W-1:0] m_entry_count,
    output logic [31:0]      m_last_stream_id,
    output logic [31:0]      m_last_seq_number,
    output logic [62:0]      m_last_sent_time,
    output logic             m_read_valid,
    output logic [31:0]      m_read_stream_id,
    output logic [31:0]      m_read_seq_number,
    output logic [62:0]      m_read_sent_time,
    output logic [31:0]      m_read_payload_tag
);

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CMP_W = CNT_W + 6;

    state_t     state_reg, state_next;
    opcode_t    op_reg;
    entry_t     in_reg;
    logic [5:0] idx_reg;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             gap_reg, gap_next;
    entry_t           last_reg, last_next;
    entry_t           rd_reg;

    status_t          status_reg, status_next;
    logic             acc_reg, acc_next;
    logic             rvalid_reg, rvalid_next;
    entry_t           rout_reg, rout_next;

    cell_ctrl_t       cell_ctrl;
    logic             do_insert;
    entry_t           entry_vec [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] le_vec;
    logic [STORE_DEPTH-1:0] hit_vec;

    logic [CNT_W-1:0]   cnt_dec;
    logic [IDX_W+5:0]   idx_wide;
    logic [IDX_W-1:0]   rd_addr;
    logic               full;
    logic               held_any;
    logic               in_valid_msg;
    logic               is_dup;
    logic               is_first;
    logic               is_next;
    logic               idx_in_range;

    // cell chain
    for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
        smr_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .new_entry  (in_reg),
            .left_entry ((i == 0) ? in_reg : entry_vec[(i == 0) ? 0 : i - 1]),
            .left_le    ((i == 0) ? 1'b1 : le_vec[(i == 0) ? 0 : i - 1]),
            .count      (cnt_reg),
            .entry      (entry_vec[i]),
            .le         (le_vec[i]),
            .hit        (hit_vec[i])
        );
    end

    // state machine
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_EVAL;
            S_EVAL:  state_next = S_APPLY;
            S_APPLY: state_next = S_RESP;
            S_RESP:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = (state_reg == S_IDLE);
        m_valid          = (state_reg == S_RESP);
        cell_ctrl.eval   = (state_reg == S_EVAL);
        cell_ctrl.insert = (state_reg == S_APPLY) && do_insert;
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg                <= opcode_t'(s_opcode);
            in_reg.stream_id      <= s_stream_id;
            in_reg.seq_number     <= s_seq_number;
            in_reg.sent_time      <= s_sent_time;
            in_reg.payload_tag    <= s_payload_tag;
            idx_reg               <= s_read_index;
        end
    end

    // read select: requested index, or the top entry for clear
    assign cnt_dec  = cnt_reg - 1'b1;
    assign idx_wide = (IDX_W + 6)'(idx_reg);
    assign rd_addr  = (op_reg == OP_CLEAR) ? cnt_dec[IDX_W-1:0] : idx_wide[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (state_reg == S_EVAL) begin
            rd_reg <= entry_vec[rd_addr];
        end
    end

    // commit decision
    assign full         = (cnt_reg == CNT_W'(STORE_DEPTH));
    assign held_any     = |hit_vec;
    assign in_valid_msg = ($signed(in_reg.seq_number) > 32'sd0) &&
                          ($signed(in_reg.stream_id) >= 32'sd0);
    assign is_dup       = (in_reg.stream_id == last_reg.stream_id) &&
                          ($signed(in_reg.seq_number) <= $signed(last_reg.seq_number));
    assign is_first     = (last_reg.stream_id == '0) && (last_reg.seq_number == '0) &&
                          (last_reg.sent_time == '0);
    assign is_next      = (in_reg.stream_id == last_reg.stream_id) &&
                          (last_reg.seq_number == in_reg.seq_number - 32'd1);
    assign idx_in_range = CMP_W'(idx_reg) < CMP_W'(cnt_reg);

    always_comb begin
        status_next  = ST_INVALID;
        acc_next     = 1'b0;
        rvalid_next  = 1'b0;
        rout_next    = '0;
        do_insert    = 1'b0;
        gap_next     = gap_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        unique case (op_reg)
            OP_LIVE: begin
                if (!in_valid_msg) begin
                    status_next = ST_INVALID;
                end else if (is_dup) begin
                    status_next = ST_DUPLICATE;
                    last_next   = in_reg;
                end else if ((!is_first && !is_next) || gap_reg) begin
                    gap_next = 1'b1;
                    if (full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        status_next = ST_BUFFERED;
                        acc_next    = 1'b1;
                        do_insert   = 1'b1;
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end else begin
                    status_next = ST_IN_ORDER;
                    last_next   = in_reg;
                end
            end
            OP_BACKFILL: begin
                if (!gap_reg) begin
                    status_next = ST_NOT_BUFFER;
                end else begin
                    acc_next = 1'b1;
                    if (is_dup || held_any) begin
                        status_next = ST_BF_SKIPPED;
                    end else if (full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        status_next = ST_BF_ADDED;
                        do_insert   = 1'b1;
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
            end
            OP_READ: begin
                status_next = ST_READ;
                if (idx_in_range) begin
                    rvalid_next = 1'b1;
                    rout_next   = rd_reg;
                end
            end
            OP_CLEAR: begin
                status_next = ST_CLEARED;
                if (cnt_reg != '0) begin
                    last_next             = rd_reg;
                    last_next.payload_tag = last_reg.payload_tag;
                    cnt_next              = '0;
                    gap_next              = 1'b0;
                end
            end
            default: status_next = ST_INVALID;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            gap_reg  <= 1'b0;
            last_reg <= '0;
        end else if (state_reg == S_APPLY) begin
            cnt_reg  <= cnt_next;
            gap_reg  <= gap_next;
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_APPLY) begin
            status_reg <= status_next;
            acc_reg    <= acc_next;
            rvalid_reg <= rvalid_next;
            rout_reg   <= rout_next;
        end
    end

    assign m_status           = status_reg;
    assign m_accepted         = acc_reg;
    assign m_buffering        = gap_reg;
    assign m_entry_count      = cnt_reg;
    assign m_last_stream_id   = last_reg.stream_id;
    assign m_last_seq_number  = last_reg.seq_number;
    assign m_last_sent_time   = last_reg.sent_time;
    assign m_read_valid       = rvalid_reg;
    assign m_read_stream_id   = rout_reg.stream_id;
    assign m_read_seq_number  = rout_reg.seq_number;
    assign m_read_sent_time   = rout_reg.sent_time;
    assign m_read_payload_tag = rout_reg.payload_tag;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(STORE_DEPTH))
        else $error("entry count above store depth");

    a_held_needs_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != '0) |-> gap_reg)
        else $error("entries held while not buffering");

    a_sorted_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        ((le_vec + 1'b1) & le_vec) == '0)
        else $error("store order broken");

    a_insert_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctrl.insert |-> !full)
        else $error("insert into full store");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        cell_ctrl.insert |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("count not advanced on insert");
`endif

endmodule

>>> design/smr_cell.sv
// One slot of the sorted store: holds an entry, compares it and shifts right on insert.
module smr_cell import smr_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cell_ctrl_t       ctrl,
    input  entry_t           new_entry,
    input  entry_t           left_entry,
    input  logic             left_le,
    input  logic [CNT_W-1:0] count,
    output entry_t           entry,
    output logic             le,
    output logic             hit
);

    entry_t entry_reg;
    logic   le_reg;
    logic   hit_reg;
    logic   active;

    assign active = count > CNT_W'(INDEX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            le_reg  <= 1'b0;
            hit_reg <= 1'b0;
        end else if (ctrl.eval) begin
            le_reg  <= active && key_le(entry_reg, new_entry);
            hit_reg <= active && (entry_reg.stream_id == new_entry.stream_id)
                              && (entry_reg.seq_number == new_entry.seq_number);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.insert && !le_reg) begin
            entry_reg <= left_le ? new_entry : left_entry;
        end
    end

    assign entry = entry_reg;
    assign le    = le_reg;
    assign hit   = hit_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sequenced message resequencer: directed and random traffic.
module tb_top import smr_pkg::*; ();

    localparam int DEPTH        = 64;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 24;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [3:0]  status;
        logic        accepted;
        logic        buffering;
        logic [6:0]  count;
        logic [31:0] last_id;
        logic [31:0] last_num;
        logic [62:0] last_time;
        logic        rd_valid;
        logic [31:0] rd_id;
        logic [31:0] rd_num;
        logic [62:0] rd_time;
        logic [31:0] rd_tag;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [31:0] s_stream_id;
    logic [31:0] s_seq_number;
    logic [62:0] s_sent_time;
    logic [31:0] s_payload_tag;
    logic [5:0]  s_read_index;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status;
    logic        m_accepted;
    logic        m_buffering;
    logic [6:0]  m_entry_count;
    logic [31:0] m_last_stream_id;
    logic [31:0] m_last_seq_number;
    logic [62:0] m_last_sent_time;
    logic        m_read_valid;
    logic [31:0] m_read_stream_id;
    logic [31:0] m_read_seq_number;
    logic [62:0] m_read_sent_time;
    logic [31:0] m_read_payload_tag;

    // predicted block state
    logic signed [31:0] held_key_id  [DEPTH];
    logic signed [31:0] held_key_num [DEPTH];
    logic [62:0]        held_time    [DEPTH];
    logic [31:0]        held_tag     [DEPTH];
    int                 held_fill = 0;
    bit                 gap_on = 1'b0;
    logic signed [31:0] mark_id = '0;
    logic signed [31:0] mark_num = '0;
    logic [62:0]        mark_time = '0;

    outcome_t           pending_outcomes[$];
    outcome_t           oldest;
    logic signed [31:0] cur_id = '0;
    logic signed [31:0] cur_num = '0;
    int                 error_count = 0;
    int                 idle_cycles = 0;
    int                 ready_hold = 0;
    bit                 no_idle = 1'b0;

    sequenced_message_resequencer_unit u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_opcode           (s_opcode),
        .s_stream_id        (s_stream_id),
        .s_seq_number       (s_seq_number),
        .s_sent_time        (s_sent_time),
        .s_payload_tag      (s_payload_tag),
        .s_read_index       (s_read_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_accepted         (m_accepted),
        .m_buffering        (m_buffering),
        .m_entry_count      (m_entry_count),
        .m_last_stream_id   (m_last_stream_id),
        .m_last_seq_number  (m_last_seq_number),
        .m_last_sent_time   (m_last_sent_time),
        .m_read_valid       (m_read_valid),
        .m_read_stream_id   (m_read_stream_id),
        .m_read_seq_number  (m_read_seq_number),
        .m_read_sent_time   (m_read_sent_time),
        .m_read_payload_tag (m_read_payload_tag)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit store_insert(logic signed [31:0] id, logic signed [31:0] num,
                                        logic [62:0] t, logic [31:0] tag);
        int pos;
        int k;
        pos = 0;
        if (held_fill >= DEPTH) return 1'b0;
        while (pos < held_fill && (held_key_id[pos] < id ||
               (held_key_id[pos] == id && held_key_num[pos] <= num))) pos++;
        for (k = held_fill; k > pos; k--) begin
            held_key_id[k]  = held_key_id[k-1];
            held_key_num[k] = held_key_num[k-1];
            held_time[k]    = held_time[k-1];
            held_tag[k]     = held_tag[k-1];
        end
        held_key_id[pos]  = id;
        held_key_num[pos] = num;
        held_time[pos]    = t;
        held_tag[pos]     = tag;
        held_fill++;
        return 1'b1;
    endfunction

    function automatic bit store_holds(logic signed [31:0] id, logic signed [31:0] num);
        int k;
        for (k = 0; k < held_fill; k++) begin
            if (held_key_id[k] == id && held_key_num[k] == num) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic outcome_t resequence_step(opcode_t op, logic signed [31:0] id,
                                                 logic signed [31:0] num, logic [62:0] t,
                                                 logic [31:0] tag, logic [5:0] idx);
        outcome_t o;
        bit first;
        bit next;
        int top;
        o = '0;
        case (op)
            OP_LIVE: begin
                if (num <= 0 || id < 0) begin
                    o.status = ST_INVALID;
                end else if (id == mark_id && num <= mark_num) begin
                    mark_id   = id;
                    mark_num  = num;
                    mark_time = t;
                    o.status  = ST_DUPLICATE;
                end else begin
                    first = (mark_id == 0 && mark_num == 0 && mark_time == 0);
                    next  = (id == mark_id && mark_num == num - 1);
                    if (!(first || next) || gap_on) begin
                        gap_on = 1'b1;
                        if (store_insert(id, num, t, tag)) begin
                            o.status   = ST_BUFFERED;
                            o.accepted = 1'b1;
                        end else begin
                            o.status = ST_OVERFLOW;
                        end
                    end else begin
                        mark_id   = id;
                        mark_num  = num;
                        mark_time = t;
                        o.status  = ST_IN_ORDER;
                    end
                end
            end
            OP_BACKFILL: begin
                if (!gap_on) begin
                    o.status = ST_NOT_BUFFER;
                end else begin
                    o.accepted = 1'b1;
                    if ((id == mark_id && num <= mark_num) || store_holds(id, num))
                        o.status = ST_BF_SKIPPED;
                    else if (store_insert(id, num, t, tag))
                        o.status = ST_BF_ADDED;
                    else
                        o.status = ST_OVERFLOW;
                end
            end
            OP_READ: begin
                o.status = ST_READ;
                if (idx < held_fill) begin
                    o.rd_valid = 1'b1;
                    o.rd_id    = held_key_id[idx];
                    o.rd_num   = held_key_num[idx];
                    o.rd_time  = held_time[idx];
                    o.rd_tag   = held_tag[idx];
                end
            end
            default: begin
                o.status = ST_CLEARED;
                if (held_fill > 0) begin
                    top       = held_fill - 1;
                    mark_id   = held_key_id[top];
                    mark_num  = held_key_num[top];
                    mark_time = held_time[top];
                    held_fill = 0;
                    gap_on    = 1'b0;
                end
            end
        endcase
        o.buffering = gap_on;
        o.count     = held_fill[6:0];
        o.last_id   = mark_id;
        o.last_num  = mark_num;
        o.last_time = mark_time;
        return o;
    endfunction

    task automatic note_error(string msg);
        if (error_count < PRINT_LIMIT) $display("%0t mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, logic [62:0] got, logic [62:0] want);
        if (got !== want) note_error($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic send_item(opcode_t op, logic [31:0] id, logic [31:0] num,
                             logic [62:0] t, logic [31:0] tag, logic [5:0] idx);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_opcode      <= op;
        s_stream_id   <= id;
        s_seq_number  <= num;
        s_sent_time   <= t;
        s_payload_tag <= tag;
        s_read_index  <= idx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_outcomes.push_back(resequence_step(op, id, num, t, tag, idx));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    task automatic test_entry_rules();
        send_item(OP_READ, 0, 0, 0, 0, 6'd0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 6'd0);
        send_item(OP_BACKFILL, 5, 7, 63'd11, 32'h1, 6'd0);
        send_item(OP_LIVE, -1, 10, 63'd12, 32'h2, 6'd0);
        send_item(OP_LIVE, 5, 0, 63'd13, 32'h3, 6'd0);
        send_item(OP_LIVE, 5, 32'h8000_0000, 63'd14, 32'h4, 6'd0);
        send_item(OP_LIVE, 5, 100, 63'd1000, 32'h5, 6'd0);
        send_item(OP_LIVE, 5, 101, 63'd1001, 32'h6, 6'd0);
        send_item(OP_LIVE, 5, 101, 63'd1002, 32'h7, 6'd0);
        send_item(OP_LIVE, 5, 50, 63'd1003, 32'h8, 6'd0);
        send_item(OP_LIVE, 5, 51, 63'd1004, 32'h9, 6'd0);
    endtask

    task automatic test_gap_backfill();
        send_item(OP_LIVE, 5, 55, 63'd2000, 32'hA, 6'd0);
        send_item(OP_LIVE, 5, 53, 63'd2001, 32'hB, 6'd0);
        send_item(OP_BACKFILL, 5, 52, 63'd2002, 32'hC, 6'd0);
        send_item(OP_BACKFILL, 5, 52, 63'd2003, 32'hD, 6'd0);
        send_item(OP_BACKFILL, 5, 40, 63'd2004, 32'hE, 6'd0);
        send_item(OP_BACKFILL, -7, 3, 63'd2005, 32'hF, 6'd0);
        send_item(OP_LIVE, 5, 55, 63'd2006, 32'h10, 6'd0);
        send_item(OP_READ, 0, 0, 0, 0, 6'd3);
        send_item(OP_READ, 0, 0, 0, 0, 6'd4);
        send_item(OP_READ, 0, 0, 0, 0, 6'd63);
        send_item(OP_CLEAR, 0, 0, 0, 0, 6'd0);
        send_item(OP_BACKFILL, 5, 56, 63'd2007, 32'h11, 6'd0);
    endtask

    task automatic test_extremes();
        send_item(OP_LIVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1);
        send_item(OP_BACKFILL, 32'h8000_0000, 32'h8000_0000, '0, '0, '0);
        send_item(OP_READ, 0, 0, 0, 0, 6'd0);
        send_item(OP_READ, 0, 0, 0, 0, 6'd1);
        send_item(OP_CLEAR, 0, 0, 0, 0, 6'd0);
        send_item(OP_LIVE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd5, 32'h12, 6'd0);
    endtask

    task automatic test_overflow();
        logic [63:0] r64;
        wait_drained();
        while (held_fill < DEPTH) begin
            r64 = {$urandom, $urandom};
            send_item(OP_LIVE, 9, $urandom_range(1, 5000), r64[62:0], $urandom, 6'd0);
        end
        send_item(OP_LIVE, 9, 6000, 63'd77, 32'h13, 6'd0);
        send_item(OP_BACKFILL, 9, 7000, 63'd78, 32'h14, 6'd0);
        send_item(OP_BACKFILL, held_key_id[0], held_key_num[0], 63'd79, 32'h15, 6'd0);
        send_item(OP_READ, 0, 0, 0, 0, 6'd63);
        send_item(OP_CLEAR, 0, 0, 0, 0, 6'd0);
    endtask

    task automatic send_random_item();
        int pick;
        logic [63:0] r64;
        logic [31:0] id;
        logic [31:0] num;
        logic [5:0]  idx;
        pick = $urandom_range(0, 99);
        r64  = {$urandom, $urandom};
        if ($urandom_range(0, 15) == 0) r64 = '0;
        idx = 6'($urandom_range(0, 63));
        if (!gap_on) begin
            cur_id  = mark_id;
            cur_num = mark_num;
        end
        if (pick < 40) begin
            cur_num = cur_num + 1;
            send_item(OP_LIVE, cur_id, cur_num, r64[62:0], $urandom, idx);
        end else if (pick < 50) begin
            cur_num = cur_num + $urandom_range(2, 6);
            send_item(OP_LIVE, cur_id, cur_num, r64[62:0], $urandom, idx);
        end else if (pick < 54) begin
            cur_id  = cur_id + $urandom_range(1, 3);
            cur_num = $urandom_range(1, 20);
            send_item(OP_LIVE, cur_id, cur_num, r64[62:0], $urandom, idx);
        end else if (pick < 60) begin
            num = mark_num - $urandom_range(0, 3);
            send_item(OP_LIVE, mark_id, num, r64[62:0], $urandom, idx);
        end else if (pick < 74) begin
            id  = ($urandom_range(0, 3) == 0) ? cur_id : mark_id;
            num = mark_num + $urandom_range(0, 8) - 1;
            send_item(OP_BACKFILL, id, num, r64[62:0], $urandom, idx);
        end else if (pick < 84) begin
            if ($urandom_range(0, 3) != 0)
                idx = 6'($urandom_range(0, (held_fill < 63) ? held_fill + 1 : 63));
            send_item(OP_READ, $urandom, $urandom, r64[62:0], $urandom, idx);
        end else if (pick < 91) begin
            send_item(OP_CLEAR, $urandom, $urandom, r64[62:0], $urandom, idx);
        end else begin
            send_item(opcode_t'($urandom_range(0, 3)), $urandom, $urandom, r64[62:0],
                      $urandom, idx);
        end
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 4; phase++) begin
            no_idle = (phase == 2);
            repeat (250) send_random_item();
            if (phase == 1) wait_drained();
        end
        no_idle = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            ready_hold = no_idle ? 0 : $urandom_range(0, 7);
            if (pending_outcomes.size() == 0) begin
                note_error("result with nothing outstanding");
            end else begin
                oldest = pending_outcomes.pop_front();
                check_field("status", 63'(m_status), 63'(oldest.status));
                check_field("accepted", 63'(m_accepted), 63'(oldest.accepted));
                check_field("buffering", 63'(m_buffering), 63'(oldest.buffering));
                check_field("entry_count", 63'(m_entry_count), 63'(oldest.count));
                check_field("last_stream_id", 63'(m_last_stream_id), 63'(oldest.last_id));
                check_field("last_seq_number", 63'(m_last_seq_number), 63'(oldest.last_num));
                check_field("last_sent_time", m_last_sent_time, oldest.last_time);
                check_field("read_valid", 63'(m_read_valid), 63'(oldest.rd_valid));
                check_field("read_stream_id", 63'(m_read_stream_id), 63'(oldest.rd_id));
                check_field("read_seq_number", 63'(m_read_seq_number), 63'(oldest.rd_num));
                check_field("read_sent_time", m_read_sent_time, oldest.rd_time);
                check_field("read_payload_tag", 63'(m_read_payload_tag), 63'(oldest.rd_tag));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_opcode      = '0;
        s_stream_id   = '0;
        s_seq_number  = '0;
        s_sent_time   = '0;
        s_payload_tag = '0;
        s_read_index  = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_entry_rules();
        test_gap_backfill();
        test_extremes();
        test_overflow();
        test_random_traffic();

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_outcomes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
